// File: design/blockchain_block_stream_parser_assert.svh
// assertion macros used by the parser queue module (bbsp_back)
`ifndef BLOCKCHAIN_BLOCK_STREAM_PARSER_ASSERT_SVH
`define BLOCKCHAIN_BLOCK_STREAM_PARSER_ASSERT_SVH

// implication checked on every clock edge outside reset
`define BBSP_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// condition that must never be true outside reset
`define BBSP_ASSERT_NEVER(label, clk, rst_n, a) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(a)) \
        else $error("assertion failed");

`endif

// File: design/bbsp_pkg.sv
package bbsp_pkg;

    localparam int HASH_BYTES = 32;
    localparam int QDEPTH = 4;
    localparam int QAW = 2;

    typedef enum logic [4:0] {
        ST_MAGIC     = 5'd0,
        ST_SIZE      = 5'd1,
        ST_VERSION   = 5'd2,
        ST_PREV      = 5'd3,
        ST_MERKLE    = 5'd4,
        ST_TIME      = 5'd5,
        ST_BITS      = 5'd6,
        ST_NONCE     = 5'd7,
        ST_TXCNT     = 5'd8,
        ST_TXVER     = 5'd9,
        ST_INCNT     = 5'd10,
        ST_INHASH    = 5'd11,
        ST_INIDX     = 5'd12,
        ST_INSLEN    = 5'd13,
        ST_INSCRIPT  = 5'd14,
        ST_SEQ       = 5'd15,
        ST_OUTCNT    = 5'd16,
        ST_OUTVAL    = 5'd17,
        ST_OUTSLEN   = 5'd18,
        ST_OUTSCRIPT = 5'd19,
        ST_LOCK      = 5'd20,
        CODE_DONE    = 5'd21
    } code_t;

    // parser states, one-hot; the set bit index equals the field code
    typedef enum logic [20:0] {
        S_MAGIC     = 21'h000001,
        S_SIZE      = 21'h000002,
        S_VERSION   = 21'h000004,
        S_PREV      = 21'h000008,
        S_MERKLE    = 21'h000010,
        S_TIME      = 21'h000020,
        S_BITS      = 21'h000040,
        S_NONCE     = 21'h000080,
        S_TXCNT     = 21'h000100,
        S_TXVER     = 21'h000200,
        S_INCNT     = 21'h000400,
        S_INHASH    = 21'h000800,
        S_INIDX     = 21'h001000,
        S_INSLEN    = 21'h002000,
        S_INSCRIPT  = 21'h004000,
        S_SEQ       = 21'h008000,
        S_OUTCNT    = 21'h010000,
        S_OUTVAL    = 21'h020000,
        S_OUTSLEN   = 21'h040000,
        S_OUTSCRIPT = 21'h080000,
        S_LOCK      = 21'h100000
    } state_t;

    typedef enum logic [1:0] {
        REG_MAIN  = 2'd0,
        REG_TEST  = 2'd1,
        REG_TEST3 = 2'd2,
        REG_ALT   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [4:0]  code;
        logic [63:0] value;
        logic [1:0]  net;
        logic [31:0] pos;
        logic        last_byte;
        logic        last_run;
    } result_t;

    // one parsed byte: up to two results
    typedef struct packed {
        logic    two;
        result_t r0;
        result_t r1;
    } entry_t;

    // field code of the field a state is collecting
    function automatic logic [4:0] state_code(state_t s);
        logic [4:0] c;
        c = 5'(ST_MAGIC);
        for (int i = 0; i < $bits(state_t); i++)
        begin
            if (s[i])
                c = 5'(i);
        end
        return c;
    endfunction

endpackage

// File: design/bbsp_front.sv
module bbsp_front import bbsp_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [63:0] cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    input  logic [7:0]  in_byte,
    output logic        push,
    output entry_t      push_entry
);

    state_t      state_reg, state_next;
    logic [31:0] win_reg, win_next;
    logic [2:0]  fill_reg, fill_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [3:0]  vsz_reg, vsz_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] sleft_reg, sleft_next;
    logic [63:0] tx_reg, tx_next;
    logic [63:0] in_reg, in_next;
    logic [63:0] out_reg, out_next;
    logic [31:0] blk_reg, blk_next;
    logic [1:0]  net_reg, net_next;
    logic [31:0] m0_reg, m1_reg, m2_reg, m3_reg;

    logic [1:0]  nres;
    result_t     ra, rb;
    logic [5:0]  cinc;
    logic [63:0] shb;
    logic [63:0] vval;
    logic        vfin;
    logic [63:0] sidx;
    logic [63:0] acc_or;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m0_reg <= 32'd3686187259;
            m1_reg <= 32'd3669344250;
            m2_reg <= 32'd118034699;
            m3_reg <= 32'd4273258233;
        end
        else if (cfg_we && cfg_index[63:2] == 62'd0)
        begin
            unique case (reg_idx_t'(cfg_index[1:0]))
                REG_MAIN:  m0_reg <= cfg_data;
                REG_TEST:  m1_reg <= cfg_data;
                REG_TEST3: m2_reg <= cfg_data;
                REG_ALT:   m3_reg <= cfg_data;
                default:   m0_reg <= m0_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        win_next = win_reg;
        fill_next = fill_reg;
        cnt_next = cnt_reg;
        vsz_next = vsz_reg;
        acc_next = acc_reg;
        sleft_next = sleft_reg;
        tx_next = tx_reg;
        in_next = in_reg;
        out_next = out_reg;
        blk_next = blk_reg;
        net_next = net_reg;
        nres = 2'd0;
        ra = '0;
        rb = '0;
        cinc = cnt_reg + 6'd1;
        shb = 64'(in_byte) << {cnt_reg[2:0], 3'b000};
        acc_or = acc_reg | shb;
        vval = 64'd0;
        vfin = 1'b0;
        sidx = acc_reg - sleft_reg;

        unique case (state_reg)
            S_MAGIC:
            begin
                win_next = {in_byte, win_reg[31:8]};
                if (fill_reg < 3'd4)
                    fill_next = fill_reg + 3'd1;
                if (fill_next == 3'd4 && (win_next == m0_reg || win_next == m1_reg
                    || win_next == m2_reg || win_next == m3_reg))
                begin
                    if (win_next == m0_reg) net_next = 2'd0;
                    else if (win_next == m1_reg) net_next = 2'd1;
                    else if (win_next == m2_reg) net_next = 2'd2;
                    else net_next = 2'd3;
                    nres = 2'd1;
                    ra.code = 5'(ST_MAGIC);
                    ra.value = 64'(win_next);
                    state_next = S_SIZE;
                    cnt_next = '0;
                    vsz_next = '0;
                    acc_next = '0;
                    win_next = '0;
                    fill_next = '0;
                end
            end
            S_SIZE, S_VERSION, S_TIME, S_BITS, S_NONCE, S_TXVER, S_INIDX,
            S_SEQ, S_LOCK, S_OUTVAL:
            begin
                acc_next = acc_or;
                cnt_next = cinc;
                if (cinc >= ((state_reg == S_OUTVAL) ? 6'd8 : 6'd4))
                begin
                    nres = 2'd1;
                    ra.code = state_code(state_reg);
                    ra.value = acc_or;
                    cnt_next = '0;
                    vsz_next = '0;
                    acc_next = '0;
                    unique case (state_reg)
                        S_SIZE:    state_next = S_VERSION;
                        S_VERSION: state_next = S_PREV;
                        S_TIME:    state_next = S_BITS;
                        S_BITS:    state_next = S_NONCE;
                        S_NONCE:   state_next = S_TXCNT;
                        S_TXVER:   state_next = S_INCNT;
                        S_INIDX:   state_next = S_INSLEN;
                        S_OUTVAL:  state_next = S_OUTSLEN;
                        S_SEQ:
                        begin
                            in_next = in_reg - 64'd1;
                            state_next = (in_next == 64'd0) ? S_OUTCNT : S_INHASH;
                        end
                        default:
                        begin
                            tx_next = tx_reg - 64'd1;
                            if (tx_next == 64'd0)
                            begin
                                nres = 2'd2;
                                rb.code = CODE_DONE;
                                rb.value = 64'(blk_reg);
                                blk_next = blk_reg + 32'd1;
                                state_next = S_MAGIC;
                                win_next = '0;
                                fill_next = '0;
                            end
                            else
                                state_next = S_TXVER;
                        end
                    endcase
                end
            end
            S_PREV, S_MERKLE, S_INHASH:
            begin
                nres = 2'd1;
                ra.code = state_code(state_reg);
                ra.value = 64'(in_byte);
                ra.pos = 32'(cnt_reg);
                ra.last_byte = (32'(cnt_reg) + 32'd1 >= 32'(HASH_BYTES));
                if (!ra.last_byte)
                    cnt_next = cinc;
                else
                begin
                    cnt_next = '0;
                    vsz_next = '0;
                    acc_next = '0;
                    if (state_reg == S_PREV) state_next = S_MERKLE;
                    else if (state_reg == S_MERKLE) state_next = S_TIME;
                    else state_next = S_INIDX;
                end
            end
            S_TXCNT, S_INCNT, S_INSLEN, S_OUTCNT, S_OUTSLEN:
            begin
                if (cnt_reg == 6'd0)
                begin
                    cnt_next = 6'd1;
                    if (in_byte < 8'hFD)
                    begin
                        vfin = 1'b1;
                        vval = 64'(in_byte);
                    end
                    else
                    begin
                        vsz_next = (in_byte == 8'hFD) ? 4'd3 : (in_byte == 8'hFE) ? 4'd5 : 4'd9;
                        acc_next = '0;
                    end
                end
                else
                begin
                    acc_next = acc_reg | (64'(in_byte) << {3'(cnt_reg - 6'd1), 3'b000});
                    cnt_next = cinc;
                    if (cinc >= 6'(vsz_reg))
                    begin
                        vfin = 1'b1;
                        vval = acc_next;
                    end
                end
                if (vfin)
                begin
                    nres = 2'd1;
                    ra.code = state_code(state_reg);
                    ra.value = vval;
                    cnt_next = '0;
                    vsz_next = '0;
                    acc_next = '0;
                    unique case (state_reg)
                        S_TXCNT:
                        begin
                            tx_next = vval;
                            if (vval == 64'd0)
                            begin
                                nres = 2'd2;
                                rb.code = CODE_DONE;
                                rb.value = 64'(blk_reg);
                                blk_next = blk_reg + 32'd1;
                                state_next = S_MAGIC;
                                win_next = '0;
                                fill_next = '0;
                            end
                            else
                                state_next = S_TXVER;
                        end
                        S_INCNT:
                        begin
                            in_next = vval;
                            state_next = (vval == 64'd0) ? S_OUTCNT : S_INHASH;
                        end
                        S_OUTCNT:
                        begin
                            out_next = vval;
                            state_next = (vval == 64'd0) ? S_LOCK : S_OUTVAL;
                        end
                        default:
                        begin
                            if (vval == 64'd0)
                            begin
                                if (state_reg == S_INSLEN)
                                    state_next = S_SEQ;
                                else
                                begin
                                    out_next = out_reg - 64'd1;
                                    state_next = (out_next == 64'd0) ? S_LOCK : S_OUTVAL;
                                end
                            end
                            else
                            begin
                                state_next = (state_reg == S_INSLEN) ? S_INSCRIPT
                                                                     : S_OUTSCRIPT;
                                sleft_next = vval;
                                acc_next = vval;
                            end
                        end
                    endcase
                end
            end
            S_INSCRIPT, S_OUTSCRIPT:
            begin
                nres = 2'd1;
                ra.code = state_code(state_reg);
                ra.value = 64'(in_byte);
                ra.pos = (sidx[63:32] != 32'd0) ? 32'hFFFFFFFF : sidx[31:0];
                ra.last_byte = (sleft_reg <= 64'd1);
                sleft_next = sleft_reg - 64'd1;
                if (ra.last_byte)
                begin
                    sleft_next = '0;
                    cnt_next = '0;
                    vsz_next = '0;
                    acc_next = '0;
                    if (state_reg == S_INSCRIPT)
                        state_next = S_SEQ;
                    else
                    begin
                        out_next = out_reg - 64'd1;
                        state_next = (out_next == 64'd0) ? S_LOCK : S_OUTVAL;
                    end
                end
            end
            default:
            begin
                state_next = S_MAGIC;
                win_next = '0;
                fill_next = '0;
            end
        endcase
        ra.net = net_next;
        rb.net = net_next;
        ra.last_run = (nres == 2'd1);
        rb.last_run = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_MAGIC;
            win_reg <= '0;
            fill_reg <= '0;
            cnt_reg <= '0;
            vsz_reg <= '0;
            acc_reg <= '0;
            sleft_reg <= '0;
            tx_reg <= '0;
            in_reg <= '0;
            out_reg <= '0;
            blk_reg <= '0;
            net_reg <= '0;
        end
        else if (in_valid)
        begin
            state_reg <= state_next;
            win_reg <= win_next;
            fill_reg <= fill_next;
            cnt_reg <= cnt_next;
            vsz_reg <= vsz_next;
            acc_reg <= acc_next;
            sleft_reg <= sleft_next;
            tx_reg <= tx_next;
            in_reg <= in_next;
            out_reg <= out_next;
            blk_reg <= blk_next;
            net_reg <= net_next;
        end
    end

    assign push = in_valid && (nres != 2'd0);
    assign push_entry = '{two: (nres == 2'd2), r0: ra, r1: rb};

endmodule

// File: design/bbsp_back.sv
module bbsp_back import bbsp_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  entry_t  push_entry,
    output logic    room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    `include "blockchain_block_stream_parser_assert.svh"

    entry_t        mem [QDEPTH];
    logic [QAW-1:0] wp_reg, rp_reg;
    logic [QAW:0]   cnt_reg;
    logic           half_reg;
    logic           pop_ent;
    entry_t         head;

    assign head = mem[rp_reg];
    assign out_valid = (cnt_reg != '0);
    assign out_res = half_reg ? head.r1 : head.r0;
    assign pop_ent = out_valid && out_ready && (half_reg || !head.two);
    // keep one free slot so a push never meets a full queue
    assign room = (cnt_reg < (QAW+1)'(QDEPTH - 1)) || pop_ent;

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
            half_reg <= 1'b0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop_ent)
            begin
                rp_reg <= rp_reg + 1'b1;
                half_reg <= 1'b0;
            end
            else if (out_valid && out_ready)
                half_reg <= 1'b1;
            cnt_reg <= cnt_reg + (QAW+1)'(push) - (QAW+1)'(pop_ent);
        end
    end

    `BBSP_ASSERT_NEVER(a_overflow, clk, rst_n, push && cnt_reg == (QAW+1)'(QDEPTH))
    `BBSP_ASSERT_IMP(a_half, clk, rst_n, half_reg, out_valid && head.two)
    `BBSP_ASSERT_NEVER(a_count, clk, rst_n, cnt_reg > (QAW+1)'(QDEPTH))

endmodule

// File: design/blockchain_block_stream_parser.sv
// byte-stream block file parser
// s_axis: one raw byte per transaction (tdata[7:0] data_byte)
// m_axis: parsed field results; tdata carries field_value, byte_position,
//   field_last_byte; tuser carries field_code and net_code; tlast marks the
//   last result caused by one input byte
// cfg: write enable, register index 0..3 (main, test, test three, alternate
//   chain magic) and 32-bit data; the user must write them only while idle;
//   the block does not enforce this
// throughput: one input byte per cycle while the queue has room; a byte
//   producing two results (a field followed by block done) is sent as two
//   transfers on the single output port, one result each
// a four-entry queue sits between the parser and the output; the input is
//   held off only when three result entries are waiting and none is popped,
//   so a stalled receiver stops input once three bytes that produced results are queued
// reset: parser returns to magic search, block number zero, magic registers
//   take their defaults, queue empties
module blockchain_block_stream_parser import bbsp_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [63:0]  cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // data_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,   // field_value, byte_position, field_last_byte
    output logic [6:0]   m_axis_tuser,   // field_code, net_code
    output logic         m_axis_tlast
);

    logic    push;
    entry_t  pe;
    logic    room;
    result_t r;

    bbsp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (s_axis_tvalid && room),
        .in_byte    (s_axis_tdata),
        .push       (push),
        .push_entry (pe)
    );

    bbsp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (pe),
        .room       (room),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_res    (r)
    );

    assign s_axis_tready = room;
    assign m_axis_tdata = {7'd0, r.last_byte, r.pos, r.value};
    assign m_axis_tuser = {r.net, r.code};
    assign m_axis_tlast = r.last_run;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import bbsp_pkg::*;

    localparam int RANDOM_ITEMS = 500;
    localparam int PHASES = 5;
    localparam int HOLD_AT = 300;
    localparam int HOLD_LEN = 300;
    localparam logic [31:0] MAIN_RST = 32'hDBB6C0FB;

    typedef struct {
        code_t       code;
        logic [63:0] value;
        logic [1:0]  net;
        logic [31:0] pos;
        logic        last_byte;
        logic        last_run;
    } parse_result_t;

    typedef struct {
        logic [7:0]  data;
        bit          typed;
        code_t       code;
        logic [63:0] value;
    } dir_row_t;

    logic         clk = 0;
    logic         rst_n = 0;
    logic         cfg_we = 0;
    logic [63:0]  cfg_index = '0;
    logic [31:0]  cfg_data = '0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [7:0]   s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [103:0] m_tdata;   // field_value, byte_position, field_last_byte
    logic [6:0]   m_tuser;   // field_code, net_code
    logic         m_tlast;

    blockchain_block_stream_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .m_axis_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    // parser image
    logic [31:0]   magic_reg [4];
    code_t         pst;
    logic [31:0]   win;
    int            wfill;
    int            fbc;
    int            vsize;
    logic [63:0]   acc;
    logic [63:0]   script_left;
    logic [63:0]   tx_left;
    logic [63:0]   in_left;
    logic [63:0]   out_left;
    logic [31:0]   block_num;
    logic [1:0]    net_latch;
    parse_result_t step_res [2];
    int            step_n;

    parse_result_t expected_fields [$];
    logic [7:0]    byte_plan [$];
    int            errors = 0;
    int            fields_checked = 0;
    int            blocks_checked = 0;
    int            bytes_sent = 0;

    dir_row_t directed_rows [18] = '{
        '{8'h00, 0, ST_MAGIC, 64'h0},
        '{8'hFF, 0, ST_MAGIC, 64'h0},
        '{8'h55, 0, ST_MAGIC, 64'h0},
        '{MAIN_RST[7:0], 0, ST_MAGIC, 64'h0},
        '{MAIN_RST[15:8], 0, ST_MAGIC, 64'h0},
        '{MAIN_RST[23:16], 0, ST_MAGIC, 64'h0},
        '{MAIN_RST[31:24], 1, ST_MAGIC, 64'(MAIN_RST)},
        '{8'hFF, 0, ST_SIZE, 64'h0},
        '{8'hFF, 0, ST_SIZE, 64'h0},
        '{8'hFF, 0, ST_SIZE, 64'h0},
        '{8'hFF, 1, ST_SIZE, 64'hFFFF_FFFF},
        '{8'h00, 0, ST_VERSION, 64'h0},
        '{8'h00, 0, ST_VERSION, 64'h0},
        '{8'h00, 0, ST_VERSION, 64'h0},
        '{8'h00, 1, ST_VERSION, 64'h0},
        '{8'hFF, 1, ST_PREV, 64'hFF},
        '{8'h00, 1, ST_PREV, 64'h00},
        '{8'hA5, 1, ST_PREV, 64'hA5}
    };

    function automatic void emit(code_t code, logic [63:0] value, logic [31:0] pos,
                                 logic last_byte);
        if (step_n >= 2)
            return;
        step_res[step_n] = '{code, value, net_latch, pos, last_byte, 1'b0};
        step_n++;
    endfunction

    function automatic void go_search();
        pst = ST_MAGIC;
        win = '0;
        wfill = 0;
    endfunction

    function automatic void enter(code_t st);
        pst = st;
        fbc = 0;
        vsize = 0;
        acc = '0;
    endfunction

    function automatic void finish_block();
        emit(CODE_DONE, 64'(block_num), '0, 1'b0);
        block_num++;
        go_search();
    endfunction

    function automatic void finish_tx();
        tx_left--;
        if (tx_left == 0)
            finish_block();
        else
            enter(ST_TXVER);
    endfunction

    function automatic void finish_output();
        out_left--;
        enter(out_left == 0 ? ST_LOCK : ST_OUTVAL);
    endfunction

    function automatic void fixed_done(logic [63:0] v);
        code_t st;
        st = pst;
        emit(st, v, '0, 1'b0);
        case (st)
            ST_SIZE:    enter(ST_VERSION);
            ST_VERSION: enter(ST_PREV);
            ST_TIME:    enter(ST_BITS);
            ST_BITS:    enter(ST_NONCE);
            ST_NONCE:   enter(ST_TXCNT);
            ST_TXVER:   enter(ST_INCNT);
            ST_INIDX:   enter(ST_INSLEN);
            ST_SEQ:
            begin
                in_left--;
                enter(in_left == 0 ? ST_OUTCNT : ST_INHASH);
            end
            ST_OUTVAL:  enter(ST_OUTSLEN);
            ST_LOCK:    finish_tx();
            default:    go_search();
        endcase
    endfunction

    function automatic void varint_done(logic [63:0] v);
        code_t st;
        st = pst;
        emit(st, v, '0, 1'b0);
        case (st)
            ST_TXCNT:
            begin
                tx_left = v;
                if (v == 0)
                    finish_block();
                else
                    enter(ST_TXVER);
            end
            ST_INCNT:
            begin
                in_left = v;
                enter(v == 0 ? ST_OUTCNT : ST_INHASH);
            end
            ST_OUTCNT:
            begin
                out_left = v;
                enter(v == 0 ? ST_LOCK : ST_OUTVAL);
            end
            ST_INSLEN, ST_OUTSLEN:
            begin
                if (v == 0)
                begin
                    if (st == ST_INSLEN)
                        enter(ST_SEQ);
                    else
                        finish_output();
                end
                else
                begin
                    enter(st == ST_INSLEN ? ST_INSCRIPT : ST_OUTSCRIPT);
                    script_left = v;
                    acc = v;
                end
            end
            default: go_search();
        endcase
    endfunction

    function automatic void magic_step(logic [7:0] b);
        win = {b, win[31:8]};
        if (wfill < 4)
            wfill++;
        if (wfill < 4)
            return;
        if (win == magic_reg[REG_MAIN])
            net_latch = 2'd0;
        else if (win == magic_reg[REG_TEST])
            net_latch = 2'd1;
        else if (win == magic_reg[REG_TEST3])
            net_latch = 2'd2;
        else if (win == magic_reg[REG_ALT])
            net_latch = 2'd3;
        else
            return;
        emit(ST_MAGIC, 64'(win), '0, 1'b0);
        enter(ST_SIZE);
        win = '0;
        wfill = 0;
    endfunction

    function automatic void fixed_step(logic [7:0] b, int len);
        acc |= 64'(b) << (8 * (fbc & 7));
        fbc++;
        if (fbc >= len)
            fixed_done(acc);
    endfunction

    function automatic void varint_step(logic [7:0] b);
        if (fbc == 0)
        begin
            fbc = 1;
            if (b < 8'hFD)
            begin
                varint_done(64'(b));
                return;
            end
            vsize = (b == 8'hFD) ? 3 : (b == 8'hFE) ? 5 : 9;
            acc = '0;
            return;
        end
        acc |= 64'(b) << (8 * ((fbc - 1) & 7));
        fbc++;
        if (fbc >= vsize)
            varint_done(acc);
    endfunction

    function automatic void hash_step(logic [7:0] b);
        code_t st;
        bit    last;
        st = pst;
        last = (fbc + 1 >= HASH_BYTES);
        emit(st, 64'(b), 32'(fbc), last);
        if (!last)
        begin
            fbc++;
            return;
        end
        if (st == ST_PREV)
            enter(ST_MERKLE);
        else if (st == ST_MERKLE)
            enter(ST_TIME);
        else
            enter(ST_INIDX);
    endfunction

    function automatic void script_step(logic [7:0] b);
        code_t       st;
        logic [63:0] idx;
        bit          last;
        st = pst;
        idx = acc - script_left;
        last = (script_left <= 1);
        emit(st, 64'(b), (idx > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : idx[31:0], last);
        script_left--;
        if (!last)
            return;
        script_left = '0;
        if (st == ST_INSCRIPT)
            enter(ST_SEQ);
        else
            finish_output();
    endfunction

    // predicts the results of one accepted byte and queues them
    function automatic void parse_byte(logic [7:0] b);
        step_n = 0;
        case (pst)
            ST_MAGIC: magic_step(b);
            ST_SIZE, ST_VERSION, ST_TIME, ST_BITS, ST_NONCE, ST_TXVER, ST_INIDX,
            ST_SEQ, ST_LOCK:
                fixed_step(b, 4);
            ST_OUTVAL: fixed_step(b, 8);
            ST_PREV, ST_MERKLE, ST_INHASH: hash_step(b);
            ST_TXCNT, ST_INCNT, ST_INSLEN, ST_OUTCNT, ST_OUTSLEN: varint_step(b);
            ST_INSCRIPT, ST_OUTSCRIPT: script_step(b);
            default: go_search();
        endcase
        if (step_n > 0)
            step_res[step_n - 1].last_run = 1'b1;
        for (int i = 0; i < step_n; i++)
            expected_fields.push_back(step_res[i]);
    endfunction

    // compact size, sometimes in a longer form than needed
    function automatic void plan_varint(logic [63:0] v);
        int form;
        int nb;
        form = $urandom_range(0, 5);
        if (v < 253 && form < 3)
        begin
            byte_plan.push_back(v[7:0]);
            return;
        end
        if (v < 64'h1_0000 && form < 4)
        begin
            byte_plan.push_back(8'hFD);
            nb = 2;
        end
        else if (v < 64'h1_0000_0000 && form < 5)
        begin
            byte_plan.push_back(8'hFE);
            nb = 4;
        end
        else
        begin
            byte_plan.push_back(8'hFF);
            nb = 8;
        end
        for (int i = 0; i < nb; i++)
            byte_plan.push_back(v[8 * i +: 8]);
    endfunction

    // next byte steered by the parser image so that most blocks are well formed
    function automatic logic [7:0] next_stream_byte();
        int          r;
        int          k;
        logic [31:0] m;
        if (byte_plan.size() != 0)
            return byte_plan.pop_front();
        case (pst)
            ST_MAGIC:
            begin
                repeat ($urandom_range(0, 2))
                    byte_plan.push_back(8'($urandom));
                m = magic_reg[$urandom_range(0, 3)];
                // a broken magic now and then
                k = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 4;
                for (int i = 0; i < k; i++)
                    byte_plan.push_back(m[8 * i +: 8]);
            end
            ST_TXCNT:
                plan_varint(($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 2));
            ST_INCNT, ST_OUTCNT:
                plan_varint($urandom_range(0, 2));
            ST_INSLEN, ST_OUTSLEN:
            begin
                r = $urandom_range(0, 15);
                plan_varint(r == 0 ? 300 : r < 4 ? 0 : $urandom_range(1, 5));
            end
            default:
                return 8'($urandom);
        endcase
        if (byte_plan.size() == 0 || fbc != 0)
            return (fbc != 0 && byte_plan.size() == 0) ? 8'h00 : byte_plan.pop_front();
        return byte_plan.pop_front();
    endfunction

    task automatic send_byte(logic [7:0] b);
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do
            @(posedge clk);
        while (!s_tready);
        parse_byte(b);
        bytes_sent++;
    endtask

    task automatic send_stream(int count);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && sent < count; i++)
            begin
                send_byte(next_stream_byte());
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_fields.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_magics(logic [31:0] v0, logic [31:0] v1, logic [31:0] v2,
                              logic [31:0] v3);
        logic [31:0] vals [4];
        vals = '{v0, v1, v2, v3};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= 64'(i);
            cfg_data <= vals[i];
            @(posedge clk);
            magic_reg[i] = vals[i];
        end
        cfg_we <= 1'b0;
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        parse_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_fields.size() == 0)
                report_mismatch("unexpected result code", 64'(m_tuser[4:0]), '0);
            else
            begin
                want = expected_fields.pop_front();
                if (m_tuser[4:0] != want.code)
                    report_mismatch("field_code", 64'(m_tuser[4:0]), 64'(want.code));
                if (m_tdata[63:0] != want.value)
                    report_mismatch("field_value", m_tdata[63:0], want.value);
                if (m_tuser[6:5] != want.net)
                    report_mismatch("net_code", 64'(m_tuser[6:5]), 64'(want.net));
                if (m_tdata[95:64] != want.pos)
                    report_mismatch("byte_position", 64'(m_tdata[95:64]), 64'(want.pos));
                if (m_tdata[96] != want.last_byte)
                    report_mismatch("field_last_byte", 64'(m_tdata[96]), 64'(want.last_byte));
                if (m_tlast != want.last_run)
                    report_mismatch("last_of_run", 64'(m_tlast), 64'(want.last_run));
                fields_checked++;
                if (want.code == CODE_DONE)
                    blocks_checked++;
            end
        end
    end

    // receiver stall pattern, with one long hold-off to fill the queue
    initial
    begin
        int cyc;
        cyc = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc == HOLD_AT)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_LEN) @(posedge clk);
            end
            case ((cyc / 64) % 3)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= cyc[0];
            endcase
        end
    end

    initial
    begin
        #5_000_000;
        $display("FAIL blockchain_block_stream_parser");
        $finish;
    end

    initial
    begin
        magic_reg = '{32'd3686187259, 32'd3669344250, 32'd118034699, 32'd4273258233};
        pst = ST_MAGIC;
        win = '0;
        wfill = 0;
        fbc = 0;
        vsize = 0;
        acc = '0;
        script_left = '0;
        tx_left = '0;
        in_left = '0;
        out_left = '0;
        block_num = '0;
        net_latch = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            send_byte(directed_rows[i].data);
            if (directed_rows[i].typed)
            begin
                if (step_n == 0 || step_res[0].code != directed_rows[i].code)
                    report_mismatch("directed code", 64'(step_res[0].code),
                                    64'(directed_rows[i].code));
                else if (step_res[0].value != directed_rows[i].value)
                    report_mismatch("directed value", step_res[0].value,
                                    directed_rows[i].value);
            end
        end
        s_tvalid <= 1'b0;

        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            case (p)
                0: ;
                1: set_magics(32'h0, 32'hFFFF_FFFF, 32'h0, $urandom);
                2: set_magics($urandom, $urandom, $urandom, $urandom);
                3: set_magics(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                default: set_magics($urandom, 32'h0, 32'hFFFF_FFFF, $urandom);
            endcase
            send_stream(RANDOM_ITEMS / PHASES);
        end

        wait_drained();
        $display("sent %0d bytes over %0d magic settings; checked %0d results, %0d blocks",
                 bytes_sent, PHASES, fields_checked, blocks_checked);
        $display("mismatches: %0d", errors);
        if (errors == 0)
            $display("PASS blockchain_block_stream_parser");
        else
            $display("FAIL blockchain_block_stream_parser");
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/bbsp_pkg.sv
design/bbsp_front.sv
design/bbsp_back.sv
design/blockchain_block_stream_parser.sv
tb/testbench.sv
